// File: design/preemptive_priority_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Preemptive priority scheduler assertion macros
// Shared property forms used by the scheduler's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pps assertion failed");

`endif

// File: design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the scheduler controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int ACT_W   = 2;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 24;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int SUM_W   = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_LD,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD,
    ST_WCALC,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic cap;
    logic clr;
    logic ld;
    logic scan_start;
    logic scan_step;
    logic upd;
    logic wcalc;
    logic fin_out;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             cnt_zero;
    logic             scan_last;
    logic             out_free;
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] left;
    logic [TIME_W-1:0]  start;
  } slot_t;

endpackage

`default_nettype wire

// File: design/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Preemptive priority scheduler over a table of MAX_TASKS tasks.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready): one beat carries action, task_id,
// arrival, burst and prio. Action clear empties the table and zeroes time
// and totals, load appends a task, tick runs the best ready task one unit.
// Result channel (rsp_valid/rsp_ready): exactly one beat per input beat,
// in order, held in an output register.
// Clear and load each run their own state before the result stage; a tick
// scans the loaded slots and drains (both skipped with an empty table),
// then updates and calculates the wait before it; an unused action goes
// straight to it. The slot table has one read port and the scan reads one
// slot per cycle. One item is in work at a time; the next is accepted once
// the current one reaches the result register, even while that beat still
// waits.
// Reset empties the table and zeroes time and totals; no clearing pass.
// A stalled receiver holds the result beat; the block finishes the next
// item and then waits for the register to free before completing it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "preemptive_priority_scheduler_unit_assert.svh"

module preemptive_priority_scheduler_unit
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [ACT_W-1:0]   action,
  input  wire logic [ID_W-1:0]    task_id,
  input  wire logic [TIME_W-1:0]  arrival,
  input  wire logic [BURST_W-1:0] burst,
  input  wire logic [PRIO_W-1:0]  prio,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic                    ran,
  output logic [ID_W-1:0]         run_id,
  output logic                    finished,
  output logic [TIME_W-1:0]       first_start,
  output logic [TIME_W-1:0]       finish_time,
  output logic [TIME_W-1:0]       wait_time,
  output logic [TIME_W-1:0]       turnaround_time,
  output logic                    all_done,
  output logic [SUM_W-1:0]        sum_wait,
  output logic [SUM_W-1:0]        sum_turnaround,
  output logic [TIME_W-1:0]       busy_ticks,
  output logic [TIME_W-1:0]       elapsed
);

  cmd_t    cmd;
  status_t sts;

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pps_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (action),
    .task_id         (task_id),
    .arrival         (arrival),
    .burst           (burst),
    .prio            (prio),
    .rsp_ready       (rsp_ready),
    .rsp_valid       (rsp_valid),
    .ran             (ran),
    .run_id          (run_id),
    .finished        (finished),
    .first_start     (first_start),
    .finish_time     (finish_time),
    .wait_time       (wait_time),
    .turnaround_time (turnaround_time),
    .all_done        (all_done),
    .sum_wait        (sum_wait),
    .sum_turnaround  (sum_turnaround),
    .busy_ticks      (busy_ticks),
    .elapsed         (elapsed)
  );

  // result register is only loaded when free, and then shows a beat
  `PPS_ASSERT_IMPL(a_fin_needs_free, cmd.fin_out, sts.out_free)
  `PPS_ASSERT_NEXT(a_fin_sets_valid, cmd.fin_out, rsp_valid)
  // no result beat appears the cycle after an item is taken
  `PPS_ASSERT_NEXT(a_accept_no_rsp, item_valid && item_ready, !$rose(rsp_valid))
  // one writer to the slot table per cycle
  `PPS_ASSERT_IMPL(a_one_writer, cmd.upd, !cmd.ld)

endmodule

`default_nettype wire

// File: design/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: takes one item, runs clear, load or the slot scan, update and
// wait calculation (none for others), then loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ctrl
  import pps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire status_t sts,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.cap = 1'b1;
          case (sts.act)
            ACT_CLEAR: state_next = ST_CLR;
            ACT_LOAD:  state_next = ST_LD;
            ACT_TICK: begin
              cmd.scan_start = 1'b1;
              state_next     = sts.cnt_zero ? ST_UPD : ST_SCAN;
            end
            default:   state_next = ST_FINAL;
          endcase
        end
      end
      ST_CLR: begin
        cmd.clr    = 1'b1;
        state_next = ST_FINAL;
      end
      ST_LD: begin
        cmd.ld     = 1'b1;
        state_next = ST_FINAL;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_WCALC;
      end
      ST_WCALC: begin
        cmd.wcalc  = 1'b1;
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.fin_out = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/pps_dp.sv
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: task table memory, one-slot-per-cycle scan, counters, running
// totals and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_dp
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 sts,
  input  wire logic [ACT_W-1:0]   action,
  input  wire logic [ID_W-1:0]    task_id,
  input  wire logic [TIME_W-1:0]  arrival,
  input  wire logic [BURST_W-1:0] burst,
  input  wire logic [PRIO_W-1:0]  prio,
  input  wire logic               rsp_ready,
  output logic                    rsp_valid,
  output logic                    ran,
  output logic [ID_W-1:0]         run_id,
  output logic                    finished,
  output logic [TIME_W-1:0]       first_start,
  output logic [TIME_W-1:0]       finish_time,
  output logic [TIME_W-1:0]       wait_time,
  output logic [TIME_W-1:0]       turnaround_time,
  output logic                    all_done,
  output logic [SUM_W-1:0]        sum_wait,
  output logic [SUM_W-1:0]        sum_turnaround,
  output logic [TIME_W-1:0]       busy_ticks,
  output logic [TIME_W-1:0]       elapsed
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  slot_t mem [MAX_TASKS];
  slot_t rd_q;
  slot_t best;
  slot_t mem_wd;
  logic  mem_we;
  logic [IDX_W-1:0] mem_wa;

  logic [ID_W-1:0]    cap_id;
  logic [TIME_W-1:0]  cap_arr;
  logic [BURST_W-1:0] cap_burst;
  logic [PRIO_W-1:0]  cap_prio;

  logic [CNT_W-1:0]  loaded_count;
  logic [CNT_W-1:0]  done_count;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] busy_total;
  logic [SUM_W-1:0]  wait_total;
  logic [SUM_W-1:0]  turn_total;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] pick;
  logic             cmp_vld;
  logic             found;
  logic             cmp_take;

  logic               res_ran;
  logic [ID_W-1:0]    res_id;
  logic               res_fin;
  logic [TIME_W-1:0]  res_start;
  logic [TIME_W-1:0]  res_turn;
  logic [TIME_W-1:0]  res_wait;

  logic               load_ok;
  logic [TIME_W-1:0]  now_inc;
  logic [TIME_W-1:0]  busy_inc;
  logic [BURST_W-1:0] left_new;
  logic [TIME_W-1:0]  start_new;
  logic               fin_now;
  logic [SUM_W:0]     wait_add;
  logic [SUM_W:0]     turn_add;
  logic [SUM_W-1:0]   wait_sum;
  logic [SUM_W-1:0]   turn_sum;

  assign sts.act       = action;
  assign sts.cnt_zero  = (loaded_count == '0);
  assign sts.scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == loaded_count);
  assign sts.out_free  = !rsp_valid || rsp_ready;

  assign load_ok  = (cap_burst != '0) && (loaded_count < CNT_W'(MAX_TASKS));
  assign cmp_take = cmp_vld && (rd_q.left != '0) && (rd_q.arrival <= now) &&
                    (!found || (rd_q.prio < best.prio));

  assign now_inc   = (now == TIME_MAX) ? now : now + TIME_W'(1);
  assign busy_inc  = (busy_total == TIME_MAX) ? busy_total : busy_total + TIME_W'(1);
  assign left_new  = best.left - BURST_W'(1);
  assign fin_now   = (left_new == '0);
  assign start_new = (best.left == best.burst) ? now : best.start;

  assign wait_add = {1'b0, wait_total} + (SUM_W + 1)'(res_wait);
  assign turn_add = {1'b0, turn_total} + (SUM_W + 1)'(res_turn);
  assign wait_sum = wait_add[SUM_W] ? {SUM_W{1'b1}} : wait_add[SUM_W-1:0];
  assign turn_sum = turn_add[SUM_W] ? {SUM_W{1'b1}} : turn_add[SUM_W-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = loaded_count[IDX_W-1:0];
    mem_wd = best;
    if (cmd.ld) begin
      mem_we         = load_ok;
      mem_wd.id      = cap_id;
      mem_wd.arrival = cap_arr;
      mem_wd.burst   = cap_burst;
      mem_wd.prio    = cap_prio;
      mem_wd.left    = cap_burst;
      mem_wd.start   = '0;
    end else if (cmd.upd) begin
      mem_we       = found;
      mem_wa       = pick;
      mem_wd.left  = left_new;
      mem_wd.start = start_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      done_count   <= '0;
      now          <= '0;
      busy_total   <= '0;
      wait_total   <= '0;
      turn_total   <= '0;
      cmp_vld      <= 1'b0;
      found        <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (cmp_take) begin
        found <= 1'b1;
      end
      if (cmd.clr) begin
        loaded_count <= '0;
        done_count   <= '0;
        now          <= '0;
        busy_total   <= '0;
        wait_total   <= '0;
        turn_total   <= '0;
      end
      if (cmd.ld && load_ok) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (cmd.upd) begin
        now <= now_inc;
        if (found) begin
          busy_total <= busy_inc;
          if (fin_now) begin
            done_count <= done_count + CNT_W'(1);
          end
        end
      end
      if (cmd.fin_out) begin
        wait_total <= wait_sum;
        turn_total <= turn_sum;
      end
      if (cmd.fin_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cap_id    <= task_id;
      cap_arr   <= arrival;
      cap_burst <= burst;
      cap_prio  <= prio;
      res_ran   <= 1'b0;
      res_id    <= '0;
      res_fin   <= 1'b0;
      res_start <= '0;
      res_turn  <= '0;
      res_wait  <= '0;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_step && !sts.scan_last) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (cmd.scan_step) begin
      cmp_idx <= scan_idx;
    end
    if (cmp_take) begin
      best <= rd_q;
      pick <= cmp_idx;
    end
    if (cmd.upd && found) begin
      res_ran <= 1'b1;
      res_id  <= best.id;
      res_fin <= fin_now;
      if (fin_now) begin
        res_start <= start_new;
        res_turn  <= now_inc - best.arrival;
      end
    end
    if (cmd.wcalc && res_fin) begin
      res_wait <= (res_turn >= TIME_W'(best.burst)) ?
                  res_turn - TIME_W'(best.burst) : '0;
    end
    if (cmd.fin_out) begin
      ran             <= res_ran;
      run_id          <= res_id;
      finished        <= res_fin;
      first_start     <= res_start;
      finish_time     <= res_fin ? now : '0;
      wait_time       <= res_wait;
      turnaround_time <= res_turn;
      all_done        <= (done_count == loaded_count);
      sum_wait        <= wait_sum;
      sum_turnaround  <= turn_sum;
      busy_ticks      <= busy_total;
      elapsed         <= now;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives clear, load, tick and unused-action beats into the scheduler and
// checks every result beat against a cycle-free model of the task table.
// ----------------------------------------------------------------------------
module tb
  import pps_pkg::*;
();

  localparam int TASKS = 16;
  localparam int ITEMS = 850;
  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic               ran;
    logic [ID_W-1:0]    run_id;
    logic               finished;
    logic [TIME_W-1:0]  first_start;
    logic [TIME_W-1:0]  finish_time;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic               all_done;
    logic [SUM_W-1:0]   sum_wait;
    logic [SUM_W-1:0]   sum_turnaround;
    logic [TIME_W-1:0]  busy_ticks;
    logic [TIME_W-1:0]  elapsed;
  } sched_rsp_t;

  class sched_scoreboard;
    slot_t             slots [TASKS];
    bit                started [TASKS];
    bit                finished_flag [TASKS];
    int                loaded;
    int                done_cnt;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] busy;
    logic [SUM_W-1:0]  wait_sum;
    logic [SUM_W-1:0]  turn_sum;
    sched_rsp_t        pending_rsp [$];
    int                errors;
    int                rsp_beats;

    function void clear_all();
      loaded = 0;
      done_cnt = 0;
      now = '0;
      busy = '0;
      wait_sum = '0;
      turn_sum = '0;
    endfunction

    function logic [TIME_W-1:0] inc_sat(logic [TIME_W-1:0] v);
      return (v == TIME_MAX) ? v : v + 1'b1;
    endfunction

    function logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, logic [TIME_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + (SUM_W + 1)'(b);
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function bit all_done_now();
      return done_cnt == loaded;
    endfunction

    function void note_item(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                            logic [TIME_W-1:0] arr, logic [BURST_W-1:0] bst,
                            logic [PRIO_W-1:0] pr);
      sched_rsp_t        r;
      bit                found;
      int                pick;
      logic [TIME_W-1:0] turn;
      r = '0;
      found = 0;
      pick = 0;
      case (act)
        ACT_CLEAR: clear_all();
        ACT_LOAD: begin
          if (bst != '0 && loaded < TASKS) begin
            slots[loaded] = '{id: id, arrival: arr, burst: bst, prio: pr, left: bst, start: '0};
            started[loaded] = 0;
            finished_flag[loaded] = 0;
            loaded++;
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < loaded; i++) begin
            if (!finished_flag[i] && slots[i].left != '0 && slots[i].arrival <= now &&
                (!found || slots[i].prio < slots[pick].prio)) begin
              found = 1;
              pick = i;
            end
          end
          if (found) begin
            if (!started[pick]) begin
              started[pick] = 1;
              slots[pick].start = now;
            end
            r.ran = 1'b1;
            r.run_id = slots[pick].id;
            slots[pick].left = slots[pick].left - 1'b1;
            busy = inc_sat(busy);
          end
          now = inc_sat(now);
          if (found && slots[pick].left == '0) begin
            finished_flag[pick] = 1;
            done_cnt++;
            turn = now - slots[pick].arrival;
            r.finished = 1'b1;
            r.first_start = slots[pick].start;
            r.finish_time = now;
            r.turnaround_time = turn;
            r.wait_time = (turn >= slots[pick].burst) ? turn - slots[pick].burst : '0;
            wait_sum = add_sat(wait_sum, r.wait_time);
            turn_sum = add_sat(turn_sum, turn);
          end
        end
        default: ;
      endcase
      r.all_done = all_done_now();
      r.sum_wait = wait_sum;
      r.sum_turnaround = turn_sum;
      r.busy_ticks = busy;
      r.elapsed = now;
      pending_rsp.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t: rsp beat %0d: %s", $time, rsp_beats, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
      if (got !== want)
        report($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    task check_result(sched_rsp_t got);
      sched_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("beat with no expectation pending");
      end else begin
        want = pending_rsp.pop_front();
        cmp_field("ran", want.ran, got.ran);
        cmp_field("run_id", want.run_id, got.run_id);
        cmp_field("finished", want.finished, got.finished);
        cmp_field("first_start", want.first_start, got.first_start);
        cmp_field("finish_time", want.finish_time, got.finish_time);
        cmp_field("wait_time", want.wait_time, got.wait_time);
        cmp_field("turnaround_time", want.turnaround_time, got.turnaround_time);
        cmp_field("all_done", want.all_done, got.all_done);
        cmp_field("sum_wait", want.sum_wait, got.sum_wait);
        cmp_field("sum_turnaround", want.sum_turnaround, got.sum_turnaround);
        cmp_field("busy_ticks", want.busy_ticks, got.busy_ticks);
        cmp_field("elapsed", want.elapsed, got.elapsed);
      end
      rsp_beats++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic [ACT_W-1:0]   action;
  logic [ID_W-1:0]    task_id;
  logic [TIME_W-1:0]  arrival;
  logic [BURST_W-1:0] burst;
  logic [PRIO_W-1:0]  prio;
  logic               rsp_valid;
  logic               rsp_ready;
  logic               ran;
  logic [ID_W-1:0]    run_id;
  logic               finished;
  logic [TIME_W-1:0]  first_start;
  logic [TIME_W-1:0]  finish_time;
  logic [TIME_W-1:0]  wait_time;
  logic [TIME_W-1:0]  turnaround_time;
  logic               all_done;
  logic [SUM_W-1:0]   sum_wait;
  logic [SUM_W-1:0]   sum_turnaround;
  logic [TIME_W-1:0]  busy_ticks;
  logic [TIME_W-1:0]  elapsed;

  sched_scoreboard model;
  int  sent;
  int  cycles;
  bit  calm;
  bit  tx_gaps;
  bit  hold_req;
  bit  hold_done;

  preemptive_priority_scheduler_unit #(.MAX_TASKS(TASKS)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("preemptive_priority_scheduler_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    sched_rsp_t got;
    if (!rst && rsp_valid && rsp_ready) begin
      got = '{ran, run_id, finished, first_start, finish_time, wait_time,
              turnaround_time, all_done, sum_wait, sum_turnaround, busy_ticks, elapsed};
      model.check_result(got);
    end
  end

  // result side: random stall bursts, quiet stretches, one long hold-off
  initial begin
    bit rx_quiet;
    rx_quiet = 0;
    rsp_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_quiet = 1'($urandom_range(0, 1));
      if (hold_req && !hold_done) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task send_item(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                 input logic [TIME_W-1:0] arr, input logic [BURST_W-1:0] bst,
                 input logic [PRIO_W-1:0] pr);
    if (!calm && tx_gaps && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    task_id <= id;
    arrival <= arr;
    burst <= bst;
    prio <= pr;
    do @(posedge clk); while (!item_ready);
    model.note_item(act, id, arr, bst, pr);
    sent++;
  endtask

  task send_plain(input logic [ACT_W-1:0] act);
    send_item(act, ID_W'($urandom), TIME_W'($urandom), BURST_W'($urandom),
              PRIO_W'($urandom));
  endtask

  task send_load();
    logic [TIME_W-1:0]  arr;
    logic [BURST_W-1:0] bst;
    logic [PRIO_W-1:0]  pr;
    int                 pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      arr = TIME_W'($urandom);
    else if (pick < 5)
      arr = model.now - ((model.now < 20) ? model.now : TIME_W'($urandom_range(0, 20)));
    else
      arr = model.now + TIME_W'($urandom_range(0, 8));
    pick = $urandom_range(0, 19);
    if (pick == 0)
      bst = BURST_W'($urandom);
    else if (pick == 1)
      bst = '0;
    else
      bst = BURST_W'($urandom_range(1, 6));
    pr = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
    send_item(ACT_LOAD, ID_W'($urandom), arr, bst, pr);
  endtask

  initial begin
    int n;
    int ticks;
    model = new();
    model.clear_all();
    sent = 0;
    calm = 0;
    tx_gaps = 1;
    hold_req = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    action = ACT_CLEAR;
    task_id = '0;
    arrival = '0;
    burst = '0;
    prio = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle tick, unused action, zero burst, field extremes, full table
    send_plain(ACT_CLEAR);
    send_plain(ACT_TICK);
    send_plain(ACT_NONE);
    send_item(ACT_LOAD, 16'h5a5a, '0, '0, 8'h01);
    send_item(ACT_LOAD, 16'hffff, '0, 16'd1, 8'h00);
    send_item(ACT_LOAD, 16'h0000, TIME_MAX, 16'd1, 8'h00);
    send_item(ACT_LOAD, 16'h1234, '0, 16'hffff, 8'hff);
    for (int k = 3; k < TASKS; k++)
      send_item(ACT_LOAD, ID_W'($urandom), TIME_W'($urandom_range(0, 2)),
                BURST_W'($urandom_range(1, 3)), PRIO_W'($urandom_range(1, 2)));
    send_item(ACT_LOAD, 16'hbeef, '0, 16'd1, 8'h00);
    repeat (3) send_plain(ACT_TICK);
    send_plain(ACT_CLEAR);

    // random episodes: optional clear, fill with interleaved ticks, then tick until done or capped
    while (sent < ITEMS) begin
      calm = (sent >= ITEMS - 120);
      if (!calm && sent > 300) hold_req = 1;
      tx_gaps = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) != 0) send_plain(ACT_CLEAR);
      n = $urandom_range(1, TASKS);
      if ($urandom_range(0, 7) == 0) n = TASKS + $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        send_load();
        if ($urandom_range(0, 3) == 0) send_plain(ACT_TICK);
        if ($urandom_range(0, 15) == 0) send_plain(ACT_NONE);
      end
      ticks = 0;
      while (!model.all_done_now() && ticks < 40) begin
        send_plain(ACT_TICK);
        ticks++;
      end
      repeat ($urandom_range(0, 2)) send_plain(ACT_TICK);
    end
    item_valid <= 1'b0;

    while (model.pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (model.errors == 0 && model.pending_rsp.size() == 0)
      $display("preemptive_priority_scheduler_unit: match");
    else
      $display("preemptive_priority_scheduler_unit: mismatch");
    $finish;
  end
endmodule
